FILE: hw/rtl/bpsu_pkg.sv
// ----------------------------------------------------------------------------
// bpsu_pkg
// Shared types and constants for the BMP pixel stream unpacker.
// ----------------------------------------------------------------------------
package bpsu_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 2;
    localparam int COLOR_W   = 3 * BYTE_W;

    // Luma weights in 0.8 fixed point, plus the rounding bias
    localparam logic [7:0] GRAY_WT_R = 8'd54;
    localparam logic [7:0] GRAY_WT_G = 8'd184;
    localparam logic [7:0] GRAY_WT_B = 8'd18;
    localparam logic [7:0] GRAY_BIAS = 8'd128;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_DEPTH  = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2,
        CFG_GRAY_OUTPUT  = 2'd3
    } cfg_index_t;

    // Input beat kinds
    typedef enum logic {
        CMD_PIXEL   = 1'b0,
        CMD_PALETTE = 1'b1
    } cmd_t;

    // Position within a 24-bit pixel (file order blue, green, red)
    typedef enum logic [1:0] {
        PHASE_BLUE  = 2'd0,
        PHASE_GREEN = 2'd1,
        PHASE_RED   = 2'd2
    } phase_t;

    typedef struct packed {
        logic              pixel_depth;
        logic [CFG_W-1:0]  image_width;
        logic [CFG_W-1:0]  image_height;
        logic              gray_output;
    } cfg_t;

    // Pixel in flight between the stream control and the color stage
    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              from_palette;
        logic              pal_miss;
        logic              gray;
        logic              end_of_row;
        logic              end_of_image;
    } pix_t;

endpackage

FILE: hw/rtl/bpsu_ram.sv
// ----------------------------------------------------------------------------
// bpsu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpsu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/bpsu_stream_ctrl.sv
// ----------------------------------------------------------------------------
// bpsu_stream_ctrl
// Byte stream tracking: padding skip, 24-bit gathering, row and image
// counters. Registers one pixel per completed pixel beat.
// ----------------------------------------------------------------------------
module bpsu_stream_ctrl
    import bpsu_pkg::*;
#(
    parameter int PALETTE_SIZE  = 256,
    parameter int MAX_DIMENSION = 16383
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              s1_ready,
    output logic              s1_valid,
    output pix_t              s1_pix
);

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int CMP_W = ((DIM_W > CFG_W) ? DIM_W : CFG_W) + 1;
    localparam logic [CMP_W-1:0] MAX_DIM_EXT = CMP_W'(MAX_DIMENSION);
    localparam logic [BYTE_W:0]  PAL_LIMIT   = (BYTE_W + 1)'(PALETTE_SIZE);

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] held_blue_reg, held_blue_next;
    logic [BYTE_W-1:0] held_green_reg, held_green_next;
    logic [DIM_W-1:0]  col_reg, col_next;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic [1:0]        pad_reg, pad_next;
    logic              done_reg, done_next;
    logic              s1_valid_reg, s1_valid_next;
    pix_t              s1_pix_reg, s1_pix_next;

    logic              accept;
    logic              produce;
    logic              eor;
    logic              eoi;
    logic [CMP_W-1:0]  width_eff;
    logic [CMP_W-1:0]  height_eff;
    logic [CMP_W-1:0]  col_inc;
    logic [CMP_W-1:0]  row_inc;
    logic [1:0]        row_bytes_lsb;

    assign in_ready = !s1_valid_reg || s1_ready;
    assign accept   = in_valid && in_ready;

    // Effective dimensions: zero acts as one, large values saturate
    always_comb
    begin
        width_eff  = CMP_W'(cfg.image_width);
        height_eff = CMP_W'(cfg.image_height);
        if (width_eff == '0)
        begin
            width_eff = CMP_W'(1);
        end
        else if (width_eff > MAX_DIM_EXT)
        begin
            width_eff = MAX_DIM_EXT;
        end
        if (height_eff == '0)
        begin
            height_eff = CMP_W'(1);
        end
        else if (height_eff > MAX_DIM_EXT)
        begin
            height_eff = MAX_DIM_EXT;
        end
    end

    assign col_inc = CMP_W'(col_reg) + CMP_W'(1);
    assign row_inc = CMP_W'(row_reg) + CMP_W'(1);
    assign eor     = (col_inc >= width_eff);
    assign eoi     = eor && (row_inc >= height_eff);

    // Row length in bytes mod 4: width*3 in 24-bit mode, width in 8-bit mode
    assign row_bytes_lsb = cfg.pixel_depth
                         ? (width_eff[1:0] + {width_eff[0], 1'b0})
                         : width_eff[1:0];

    // Stream state update
    always_comb
    begin
        phase_next      = phase_reg;
        held_blue_next  = held_blue_reg;
        held_green_next = held_green_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        pad_next        = pad_reg;
        done_next       = done_reg;
        produce         = 1'b0;

        if (accept && (cmd == CMD_PIXEL) && !done_reg)
        begin
            if (pad_reg != 2'd0)
            begin
                pad_next = pad_reg - 2'd1;
            end
            else if (cfg.pixel_depth)
            begin
                unique case (phase_reg)
                    PHASE_BLUE:
                    begin
                        held_blue_next = data_byte;
                        phase_next     = PHASE_GREEN;
                    end
                    PHASE_GREEN:
                    begin
                        held_green_next = data_byte;
                        phase_next      = PHASE_RED;
                    end
                    default:
                    begin
                        phase_next = PHASE_BLUE;
                        produce    = 1'b1;
                    end
                endcase
            end
            else
            begin
                phase_next = PHASE_BLUE;
                produce    = 1'b1;
            end

            if (produce)
            begin
                if (eor)
                begin
                    col_next = '0;
                    if (eoi)
                    begin
                        done_next = 1'b1;
                        row_next  = '0;
                    end
                    else
                    begin
                        row_next = row_inc[DIM_W-1:0];
                        pad_next = 2'd0 - row_bytes_lsb;
                    end
                end
                else
                begin
                    col_next = col_inc[DIM_W-1:0];
                end
            end
        end
    end

    // Pixel register toward the color stage
    always_comb
    begin
        s1_valid_next = produce || (s1_valid_reg && !s1_ready);
        s1_pix_next   = s1_pix_reg;
        if (produce)
        begin
            s1_pix_next.red          = data_byte;
            s1_pix_next.green        = held_green_reg;
            s1_pix_next.blue         = held_blue_reg;
            s1_pix_next.from_palette = !cfg.pixel_depth;
            s1_pix_next.pal_miss     = ({1'b0, data_byte} >= PAL_LIMIT);
            s1_pix_next.gray         = cfg.gray_output;
            s1_pix_next.end_of_row   = eor;
            s1_pix_next.end_of_image = eoi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PHASE_BLUE;
            held_blue_reg  <= '0;
            held_green_reg <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            pad_reg        <= '0;
            done_reg       <= 1'b0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_blue_reg  <= held_blue_next;
            held_green_reg <= held_green_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            pad_reg        <= pad_next;
            done_reg       <= done_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pix_reg <= s1_pix_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_pix   = s1_pix_reg;

    // Image end is sticky until reset
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("image done flag cleared without reset");

    // Padding is only skipped between whole pixels
    a_pad_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (pad_reg != 2'd0) |-> (phase_reg == PHASE_BLUE))
        else $error("padding pending in mid pixel");

    // A stalled pixel holds until the color stage takes it
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_ready) |=> (s1_valid_reg && $stable(s1_pix_reg)))
        else $error("stalled pixel lost or changed");

endmodule

FILE: hw/rtl/bpsu_color.sv
// ----------------------------------------------------------------------------
// bpsu_color
// Picks palette or direct color, applies the gray conversion and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module bpsu_color
    import bpsu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s1_valid,
    output logic               s1_ready,
    input  pix_t               s1_pix,
    input  logic [COLOR_W-1:0] pal_rdata,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BYTE_W-1:0]  red,
    output logic [BYTE_W-1:0]  green,
    output logic [BYTE_W-1:0]  blue,
    output logic               end_of_row,
    output logic               end_of_image
);

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] red_reg, green_reg, blue_reg;
    logic [BYTE_W-1:0] red_next, green_next, blue_next;
    logic              eor_reg, eoi_reg;
    logic              load;
    logic [BYTE_W-1:0] r_sel, g_sel, b_sel;
    logic [15:0]       gray_sum;

    assign s1_ready = !out_valid_reg || out_ready;
    assign load     = s1_valid && s1_ready;

    // Color source: palette entry (zero beyond the palette) or gathered bytes
    always_comb
    begin
        if (s1_pix.from_palette)
        begin
            if (s1_pix.pal_miss)
            begin
                r_sel = '0;
                g_sel = '0;
                b_sel = '0;
            end
            else
            begin
                r_sel = pal_rdata[3*BYTE_W-1:2*BYTE_W];
                g_sel = pal_rdata[2*BYTE_W-1:BYTE_W];
                b_sel = pal_rdata[BYTE_W-1:0];
            end
        end
        else
        begin
            r_sel = s1_pix.red;
            g_sel = s1_pix.green;
            b_sel = s1_pix.blue;
        end
    end

    // Luma: (54r + 184g + 18b + 128) >> 8, never above 255
    assign gray_sum = (16'(GRAY_WT_R) * 16'(r_sel)) + (16'(GRAY_WT_G) * 16'(g_sel))
                    + (16'(GRAY_WT_B) * 16'(b_sel)) + 16'(GRAY_BIAS);

    always_comb
    begin
        if (s1_pix.gray)
        begin
            red_next   = gray_sum[15:8];
            green_next = gray_sum[15:8];
            blue_next  = gray_sum[15:8];
        end
        else
        begin
            red_next   = r_sel;
            green_next = g_sel;
            blue_next  = b_sel;
        end
    end

    assign out_valid_next = load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            eor_reg   <= s1_pix.end_of_row;
            eoi_reg   <= s1_pix.end_of_image;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign end_of_row   = eor_reg;
    assign end_of_image = eoi_reg;

endmodule

FILE: hw/rtl/bmp_pixel_stream_unpacker_top.sv
// ----------------------------------------------------------------------------
// bmp_pixel_stream_unpacker_top
// Unpacks the pixel-data bytes of a bottom-up BMP image into RGB pixels.
// ----------------------------------------------------------------------------
// The block takes one beat per clock unless stalled: a pixel-data byte or a
// palette write. Palette writes land in a PALETTE_SIZE x 24 RAM and must
// precede the pixel bytes that use them; they produce no output. Row padding
// is skipped, 24-bit pixels are gathered blue, green, red, and 8-bit pixels
// look up the palette. After its last byte is accepted, a pixel is registered
// with the palette RAM read and stream counters, then passes through color
// select and gray conversion into the output register. The palette RAM's
// registered read sets that two-stage pipeline. With no stall the sustained
// rate is one byte per cycle; out_ready low backs up into in_ready after the
// two stages fill. Bytes after the image end are dropped until reset. Write
// configuration only while the block is idle. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_unpacker_top
    import bpsu_pkg::*;
#(
    parameter int PALETTE_SIZE  = 256,
    parameter int MAX_DIMENSION = 16383
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cmd,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic [BYTE_W-1:0]    palette_index,
    input  logic [BYTE_W-1:0]    palette_red,
    input  logic [BYTE_W-1:0]    palette_green,
    input  logic [BYTE_W-1:0]    palette_blue,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    red,
    output logic [BYTE_W-1:0]    green,
    output logic [BYTE_W-1:0]    blue,
    output logic                 end_of_row,
    output logic                 end_of_image
);

    localparam int PAL_AW = $clog2(PALETTE_SIZE);
    localparam logic [BYTE_W:0] PAL_LIMIT = (BYTE_W + 1)'(PALETTE_SIZE);

    cfg_t               cfg_reg;
    logic               in_accept;
    logic               pal_wr_en;
    logic               pal_rd_en;
    logic [COLOR_W-1:0] pal_rdata;
    logic               s1_valid;
    logic               s1_ready;
    pix_t               s1_pix;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_depth  <= 1'b1;
            cfg_reg.image_width  <= CFG_W'(1);
            cfg_reg.image_height <= CFG_W'(1);
            cfg_reg.gray_output  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PIXEL_DEPTH:  cfg_reg.pixel_depth  <= cfg_wdata[0];
                CFG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_wdata;
                CFG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_wdata;
                CFG_GRAY_OUTPUT:  cfg_reg.gray_output  <= cfg_wdata[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Palette access: writes beyond the palette are dropped
    assign in_accept = in_valid && in_ready;
    assign pal_wr_en = in_accept && (cmd == CMD_PALETTE)
                     && ({1'b0, palette_index} < PAL_LIMIT);
    assign pal_rd_en = in_accept && (cmd == CMD_PIXEL);

    bpsu_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_SIZE)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_wr_en),
        .wr_addr (palette_index[PAL_AW-1:0]),
        .wr_data ({palette_red, palette_green, palette_blue}),
        .rd_en   (pal_rd_en),
        .rd_addr (data_byte[PAL_AW-1:0]),
        .rd_data (pal_rdata)
    );

    bpsu_stream_ctrl #(
        .PALETTE_SIZE  (PALETTE_SIZE),
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .data_byte (data_byte),
        .s1_ready  (s1_ready),
        .s1_valid  (s1_valid),
        .s1_pix    (s1_pix)
    );

    bpsu_color u_color (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid),
        .s1_ready     (s1_ready),
        .s1_pix       (s1_pix),
        .pal_rdata    (pal_rdata),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .end_of_row   (end_of_row),
        .end_of_image (end_of_image)
    );

endmodule
